// ===== rtl/core/nbgv_pkg.sv =====
`default_nettype none
package nbgv_pkg;

  // Default depth of the request queue between front and back
  localparam int unsigned NBGV_QUEUE_DEPTH = 2;

  // Command codes on the request channel
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ACCUM = 2'd1;
  localparam logic [1:0] CMD_INTEG = 2'd2;

  // Result kinds
  localparam logic RES_FORCE = 1'b0;
  localparam logic RES_STEP  = 1'b1;

  // Register indexes (byte address 8*i)
  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_SOFTENING = 2'd1;
  localparam logic [1:0] REG_CUTOFF    = 2'd2;

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;

  // Shared arithmetic unit widths
  localparam int unsigned MUL_A_W = 96;
  localparam int unsigned MUL_B_W = 64;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_N_W = 160;
  localparam int unsigned DIV_D_W = 112;

  // Request kind decided by the front, one-hot
  typedef enum logic [2:0] {
    K_LOAD  = 3'b001,
    K_ACCUM = 3'b010,
    K_INTEG = 3'b100
  } kind_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [9:0]       body_index;
    logic             first_source;
    logic             last_source;
    logic [2:0][63:0] pos;
    logic [2:0][63:0] vel;
    logic [47:0]      source_gm;
  } item_t;

  typedef struct packed {
    kind_t            kind;
    logic [9:0]       body_index;
    logic             first_source;
    logic             last_source;
    logic [2:0][63:0] pos;
    logic [2:0][63:0] vel;
    logic [47:0]      source_gm;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic res_load;
  } exec_status_t;

  typedef struct packed {
    logic [31:0] time_step;
    logic [63:0] softening_squared;
    logic [63:0] cutoff_squared;
  } cfg_t;

  // Signed saturating add
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (((a ^ b) & SIGN64) == 64'd0 && ((a ^ r) & SIGN64) != 64'd0)
      return a[63] ? SIGN64 : MAXPOS;
    return r;
  endfunction

  // Apply sign to a magnitude and saturate; over marks bits above the low word
  function automatic logic [63:0] sat_mag(input logic [63:0] lo, input logic over,
                                          input logic neg);
    if (!neg)
      return (over || lo > MAXPOS) ? MAXPOS : lo;
    return (over || lo > SIGN64) ? SIGN64 : 64'd0 - lo;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/nbgv_front.sv =====
`default_nettype none
module nbgv_front import nbgv_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = NBGV_QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cmd_valid,
  output logic        cmd_stall,
  input  wire item_t  item,
  input  wire logic   pop,
  output entry_t      head,
  output q_status_t   status
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  entry_t           entry;
  logic             keep;
  logic             push;

  // Classify the request; unused codes are taken and dropped
  always_comb begin
    entry.body_index   = item.body_index;
    entry.first_source = item.first_source;
    entry.last_source  = item.last_source;
    entry.pos          = item.pos;
    entry.vel          = item.vel;
    entry.source_gm    = item.source_gm;
    entry.kind         = K_LOAD;
    keep               = 1'b1;
    case (item.command)
      CMD_LOAD:  entry.kind = K_LOAD;
      CMD_ACCUM: entry.kind = K_ACCUM;
      CMD_INTEG: entry.kind = K_INTEG;
      default:   keep = 1'b0;
    endcase
  end

  assign status.empty = (count == '0);
  assign status.full  = (count == FULL_CNT);
  assign cmd_stall    = status.full;
  assign push         = cmd_valid && !status.full && keep;
  assign head         = slots[rd_ptr];

  // Hold entries and advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/nbgv_mul.sv =====
`default_nettype none
module nbgv_mul import nbgv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic                    busy,
  output logic [MUL_P_W-1:0]      prod
);

  localparam int unsigned CNT_W = $clog2(MUL_B_W + 1);

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [CNT_W-1:0]   cnt;

  assign busy = (cnt != '0);

  // Shift-and-add, one multiplier bit a cycle, most significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(MUL_B_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      prod <= {prod[MUL_P_W-2:0], 1'b0} +
              (b_r[MUL_B_W-1] ? {{MUL_B_W{1'b0}}, a_r} : {MUL_P_W{1'b0}});
      b_r  <= {b_r[MUL_B_W-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/nbgv_div.sv =====
`default_nettype none
module nbgv_div import nbgv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] num,
  input  wire logic [DIV_D_W-1:0] den,
  output logic                    busy,
  output logic [63:0]             quo,
  output logic                    over
);

  localparam int unsigned CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] n_r;
  logic [DIV_D_W-1:0] d_r;
  logic [DIV_D_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W:0]   sh;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  assign busy = (cnt != '0);
  assign sh   = {rem, n_r[DIV_N_W-1]};
  assign diff = sh - {1'b0, d_r};
  assign ge   = (sh >= {1'b0, d_r});

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DIV_N_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r  <= num;
      d_r  <= den;
      rem  <= '0;
      quo  <= '0;
      over <= 1'b0;
    end else if (busy) begin
      n_r  <= {n_r[DIV_N_W-2:0], 1'b0};
      rem  <= ge ? diff[DIV_D_W-1:0] : sh[DIV_D_W-1:0];
      quo  <= {quo[62:0], ge};
      over <= over | quo[63];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/nbgv_exec.sv =====
`default_nettype none
module nbgv_exec import nbgv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire entry_t      head,
  input  wire q_status_t   q_status,
  output logic             pop,
  output exec_status_t     status,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic             result_kind,
  output logic [2:0][63:0] res_pos,
  output logic [2:0][63:0] res_vel,
  output logic [2:0][63:0] res_acc
);

  typedef enum logic [23:0] {
    ST_IDLE     = 24'h000001,
    ST_DISPATCH = 24'h000002,
    ST_SQ_GO    = 24'h000004,
    ST_SQ_WAIT  = 24'h000008,
    ST_DIST     = 24'h000010,
    ST_ROOT     = 24'h000020,
    ST_DEN_GO   = 24'h000040,
    ST_DEN_WAIT = 24'h000080,
    ST_NUM_GO   = 24'h000100,
    ST_NUM_WAIT = 24'h000200,
    ST_DIV_GO   = 24'h000400,
    ST_DIV_WAIT = 24'h000800,
    ST_TERM     = 24'h001000,
    ST_PASS_END = 24'h002000,
    ST_DV_GO    = 24'h004000,
    ST_DV_WAIT  = 24'h008000,
    ST_AT_GO    = 24'h010000,
    ST_AT_WAIT  = 24'h020000,
    ST_ATT_GO   = 24'h040000,
    ST_ATT_WAIT = 24'h080000,
    ST_VT_GO    = 24'h100000,
    ST_VT_WAIT  = 24'h200000,
    ST_AXIS_UPD = 24'h400000,
    ST_EMIT     = 24'h800000
  } state_t;

  state_t           state;
  entry_t           cur;
  logic [2:0][63:0] pos, vel, acc, prev, rsum, mag;
  logic [2:0]       neg;
  logic [9:0]       own_index;
  logic [129:0]     dsum;
  logic [63:0]      d2;
  logic [47:0]      root;
  logic [95:0]      sx;
  logic [49:0]      srem;
  logic [5:0]       scnt;
  logic [111:0]     den;
  logic [1:0]       k;
  logic [63:0]      dv, da, vt;
  logic             vns;
  logic             kind_pend;

  logic               mul_start, mul_busy;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic               div_start, div_busy, div_over;
  logic [63:0]        quo;

  logic [2:0]   src_ge;
  logic [2:0][63:0] src_mag;
  logic [98:0]  dsq_soft;
  logic         dist_skip;
  logic [51:0]  sq_sh, sq_trial, sq_diff;
  logic         sq_ge;
  logic [64:0]  msum;
  logic         msign;
  logic [63:0]  ma, mo;
  logic         out_free;

  assign out_free        = !res_valid || !res_stall;
  assign pop             = (state == ST_IDLE) && !q_status.empty;
  assign status.busy     = (state != ST_IDLE);
  assign status.res_load = (state == ST_EMIT) && out_free;

  nbgv_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (prod)
  );

  nbgv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({prod[111:0], 48'd0}),
    .den   (den),
    .busy  (div_busy),
    .quo   (quo),
    .over  (div_over)
  );

  // Separation per axis: magnitude and sign of source minus own
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src_ge[i]  = $signed(cur.pos[i]) >= $signed(pos[i]);
      src_mag[i] = src_ge[i] ? cur.pos[i] - pos[i] : pos[i] - cur.pos[i];
    end
  end

  // Softened distance squared and its skip test
  assign dsq_soft  = {1'b0, dsum[129:32]} + {35'd0, cfg.softening_squared};
  assign dist_skip = (dsq_soft[98:64] != '0) || (dsq_soft[63:0] == 64'd0) ||
                     (dsq_soft[63:0] > cfg.cutoff_squared);

  // Square root step, two radicand bits a cycle
  assign sq_sh    = {srem, sx[95:94]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);
  assign sq_diff  = sq_sh - sq_trial;

  // Acceleration plus previous acceleration, sign and magnitude
  always_comb begin
    ma = mag64(acc[k]);
    mo = mag64(prev[k]);
    if (acc[k][63] == prev[k][63]) begin
      msum  = {1'b0, ma} + {1'b0, mo};
      msign = acc[k][63];
    end else if (ma >= mo) begin
      msum  = {1'b0, ma - mo};
      msign = acc[k][63];
    end else begin
      msum  = {1'b0, mo - ma};
      msign = prev[k][63];
    end
  end

  // Operands for the shared multiplier, and the divider start
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = (state == ST_DIV_GO);
    unique case (state)
      ST_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = {32'd0, mag[k]};
        mul_b     = mag[k];
      end
      ST_DEN_GO: begin
        mul_start = 1'b1;
        mul_a     = {32'd0, d2};
        mul_b     = {16'd0, root};
      end
      ST_NUM_GO: begin
        mul_start = 1'b1;
        mul_a     = {32'd0, mag[k]};
        mul_b     = {16'd0, cur.source_gm};
      end
      ST_DV_GO: begin
        mul_start = 1'b1;
        mul_a     = {32'd0, mag64(vel[k])};
        mul_b     = {32'd0, cfg.time_step};
      end
      ST_AT_GO: begin
        mul_start = 1'b1;
        mul_a     = {32'd0, ma};
        mul_b     = {32'd0, cfg.time_step};
      end
      ST_ATT_GO: begin
        mul_start = 1'b1;
        mul_a     = prod[95:0];
        mul_b     = {32'd0, cfg.time_step};
      end
      ST_VT_GO: begin
        mul_start = 1'b1;
        mul_a     = {31'd0, msum};
        mul_b     = {32'd0, cfg.time_step};
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // Sequencer and body state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      vel       <= '0;
      acc       <= '0;
      prev      <= '0;
      rsum      <= '0;
      own_index <= '0;
      k         <= '0;
      kind_pend <= RES_FORCE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_status.empty) begin
            state <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          unique case (cur.kind)
            K_LOAD: begin
              pos       <= cur.pos;
              vel       <= cur.vel;
              acc       <= '0;
              prev      <= '0;
              rsum      <= '0;
              own_index <= cur.body_index;
              state     <= ST_IDLE;
            end
            K_ACCUM: begin
              if (cur.first_source) begin
                prev <= acc;
                rsum <= '0;
              end
              k <= '0;
              if (cur.body_index != own_index) begin
                state <= ST_SQ_GO;
              end else begin
                state <= ST_PASS_END;
              end
            end
            K_INTEG: begin
              k     <= '0;
              state <= ST_DV_GO;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_SQ_GO:  state <= ST_SQ_WAIT;
        ST_SQ_WAIT: begin
          if (!mul_busy) begin
            if (k == 2'd2) begin
              state <= ST_DIST;
            end else begin
              k     <= k + 1'b1;
              state <= ST_SQ_GO;
            end
          end
        end
        ST_DIST: begin
          state <= dist_skip ? ST_PASS_END : ST_ROOT;
        end
        ST_ROOT: begin
          if (scnt == 6'd0) begin
            state <= ST_DEN_GO;
          end
        end
        ST_DEN_GO:  state <= ST_DEN_WAIT;
        ST_DEN_WAIT: begin
          if (!mul_busy) begin
            k     <= '0;
            state <= ST_NUM_GO;
          end
        end
        ST_NUM_GO:  state <= ST_NUM_WAIT;
        ST_NUM_WAIT: begin
          if (!mul_busy) begin
            state <= ST_DIV_GO;
          end
        end
        ST_DIV_GO:  state <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (!div_busy) begin
            state <= ST_TERM;
          end
        end
        ST_TERM: begin
          rsum[k] <= sat_add(rsum[k], sat_mag(quo, div_over, neg[k]));
          if (k == 2'd2) begin
            state <= ST_PASS_END;
          end else begin
            k     <= k + 1'b1;
            state <= ST_NUM_GO;
          end
        end
        ST_PASS_END: begin
          if (cur.last_source) begin
            acc       <= rsum;
            kind_pend <= RES_FORCE;
            state     <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DV_GO:  state <= ST_DV_WAIT;
        ST_DV_WAIT: begin
          if (!mul_busy) begin
            state <= ST_AT_GO;
          end
        end
        ST_AT_GO:  state <= ST_AT_WAIT;
        ST_AT_WAIT: begin
          if (!mul_busy) begin
            state <= ST_ATT_GO;
          end
        end
        ST_ATT_GO: state <= ST_ATT_WAIT;
        ST_ATT_WAIT: begin
          if (!mul_busy) begin
            state <= ST_VT_GO;
          end
        end
        ST_VT_GO:  state <= ST_VT_WAIT;
        ST_VT_WAIT: begin
          if (!mul_busy) begin
            state <= ST_AXIS_UPD;
          end
        end
        ST_AXIS_UPD: begin
          pos[k] <= sat_add(sat_add(pos[k], dv), da);
          vel[k] <= sat_add(vel[k], vt);
          if (k == 2'd2) begin
            kind_pend <= RES_STEP;
            state     <= ST_EMIT;
          end else begin
            k     <= k + 1'b1;
            state <= ST_DV_GO;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == ST_DISPATCH) begin
      mag  <= src_mag;
      neg  <= ~src_ge;
      dsum <= '0;
    end
    if (state == ST_SQ_WAIT && !mul_busy) begin
      dsum <= dsum + {2'b00, prod[127:0]};
    end
    if (state == ST_DIST) begin
      d2   <= dsq_soft[63:0];
      sx   <= {dsq_soft[63:0], 32'd0};
      srem <= '0;
      root <= '0;
      scnt <= 6'd47;
    end
    if (state == ST_ROOT) begin
      srem <= sq_ge ? sq_diff[49:0] : sq_sh[49:0];
      root <= {root[46:0], sq_ge};
      sx   <= {sx[93:0], 2'b00};
      scnt <= scnt - 1'b1;
    end
    if (state == ST_DEN_WAIT && !mul_busy) begin
      den <= prod[111:0];
    end
    if (state == ST_DV_WAIT && !mul_busy) begin
      dv <= sat_mag(prod[79:16], |prod[MUL_P_W-1:80], vel[k][63]);
    end
    if (state == ST_ATT_WAIT && !mul_busy) begin
      da <= sat_mag(prod[96:33], |prod[MUL_P_W-1:97], acc[k][63]);
    end
    if (state == ST_VT_GO) begin
      vns <= msign;
    end
    if (state == ST_VT_WAIT && !mul_busy) begin
      vt <= sat_mag(prod[80:17], |prod[MUL_P_W-1:81], vns);
    end
  end

  // Result register; the next request proceeds while it waits
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (status.res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.res_load) begin
      result_kind <= kind_pend;
      res_pos     <= pos;
      res_vel     <= vel;
      res_acc     <= acc;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/nbody_gravity_verlet_step.sv =====
// Load, accumulate and integrate requests run one at a time in the back end,
// on the bit-serial multiplier and divider; an accumulate whose source is the
// body itself skips all arithmetic, and one beyond the cutoff skips the root,
// divide and force terms. The front queue holds QUEUE_DEPTH requests.
// Synchronous active-high reset clears the body state and loads time_step 1.0,
// softening 0, cutoff all ones.
`default_nettype none
module nbody_gravity_verlet_step import nbgv_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = NBGV_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire logic [1:0]  command,
  input  wire logic [9:0]  body_index,
  input  wire logic        first_source,
  input  wire logic        last_source,
  input  wire logic [63:0] pos_x,
  input  wire logic [63:0] pos_y,
  input  wire logic [63:0] pos_z,
  input  wire logic [63:0] vel_x,
  input  wire logic [63:0] vel_y,
  input  wire logic [63:0] vel_z,
  input  wire logic [47:0] source_gm,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic             result_kind,
  output logic [63:0]      out_pos_x,
  output logic [63:0]      out_pos_y,
  output logic [63:0]      out_pos_z,
  output logic [63:0]      out_vel_x,
  output logic [63:0]      out_vel_y,
  output logic [63:0]      out_vel_z,
  output logic [63:0]      out_acc_x,
  output logic [63:0]      out_acc_y,
  output logic [63:0]      out_acc_z
);

  cfg_t             cfg;
  item_t            item;
  entry_t           head;
  q_status_t        q_status;
  exec_status_t     exec_status;
  logic             q_pop;
  logic             cfg_write;
  logic [2:0][63:0] res_pos, res_vel, res_acc;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step         <= 32'h0001_0000;
      cfg.softening_squared <= '0;
      cfg.cutoff_squared    <= '1;
    end else if (cfg_write) begin
      case (paddr[4:3])
        REG_TIME_STEP: cfg.time_step         <= pwdata[31:0];
        REG_SOFTENING: cfg.softening_squared <= pwdata;
        REG_CUTOFF:    cfg.cutoff_squared    <= pwdata;
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_TIME_STEP: prdata = {32'd0, cfg.time_step};
      REG_SOFTENING: prdata = cfg.softening_squared;
      REG_CUTOFF:    prdata = cfg.cutoff_squared;
      default:       prdata = '0;
    endcase
  end

  // Gather the request fields
  assign item.command      = command;
  assign item.body_index   = body_index;
  assign item.first_source = first_source;
  assign item.last_source  = last_source;
  assign item.pos          = {pos_z, pos_y, pos_x};
  assign item.vel          = {vel_z, vel_y, vel_x};
  assign item.source_gm    = source_gm;

  nbgv_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .item      (item),
    .pop       (q_pop),
    .head      (head),
    .status    (q_status)
  );

  nbgv_exec u_exec (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .q_status    (q_status),
    .pop         (q_pop),
    .status      (exec_status),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .result_kind (result_kind),
    .res_pos     (res_pos),
    .res_vel     (res_vel),
    .res_acc     (res_acc)
  );

  assign out_pos_x = res_pos[0];
  assign out_pos_y = res_pos[1];
  assign out_pos_z = res_pos[2];
  assign out_vel_x = res_vel[0];
  assign out_vel_y = res_vel[1];
  assign out_vel_z = res_vel[2];
  assign out_acc_x = res_acc[0];
  assign out_acc_y = res_acc[1];
  assign out_acc_z = res_acc[2];

  // The back end takes a request only when idle and the queue holds one
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!q_status.empty && !exec_status.busy))
    else $error("request popped from empty queue or while busy");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    exec_status.res_load |-> !(res_valid && res_stall))
    else $error("result register overwritten while stalled");

  // A result appears only after the back end loaded one
  a_res_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(exec_status.res_load))
    else $error("result valid without a load");

endmodule
`default_nettype wire
